[rtl/core/glyph_cell_rect_generator_macros.svh]
// assertion macros shared by the rasteriser, sampled on clk with arst_n as reset
`ifndef GLYPH_CELL_RECT_GENERATOR_MACROS_SVH
`define GLYPH_CELL_RECT_GENERATOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define GCRG_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GCRG_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/gcrg_pkg.sv]
package gcrg_pkg;

	// cell geometry and printable range
	localparam int unsigned CELL_DOTS   = 5;
	localparam int unsigned GLYPH_COUNT = 95;
	localparam int unsigned GLYPH_BITS  = CELL_DOTS * CELL_DOTS;
	localparam logic [7:0]  FIRST_CODE  = 8'd32;
	localparam logic [7:0]  LAST_CODE   = 8'd126;
	localparam logic [4:0]  LAST_IDX    = 5'd25;
	localparam logic [2:0]  LAST_COL    = 3'd4;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_RED_POS       = 3'd2,
		REG_RED_SIZE      = 3'd3,
		REG_GREEN_POS     = 3'd4,
		REG_GREEN_SIZE    = 3'd5,
		REG_BLUE_POS      = 3'd6,
		REG_BLUE_SIZE     = 3'd7
	} reg_idx_t;

	// pixel layout
	typedef struct packed {
		logic [4:0] red_pos;
		logic [3:0] red_size;
		logic [4:0] green_pos;
		logic [3:0] green_size;
		logic [4:0] blue_pos;
		logic [3:0] blue_size;
	} layout_t;

	// stage 1: unclipped rectangle
	typedef struct packed {
		logic signed [16:0] left;
		logic signed [16:0] top;
		logic [10:0]        size;
		logic [23:0]        rgb;
		logic               last;
	} s1_t;

	// stage 2: left/top clamped at zero, raw right/bottom, converted colour
	typedef struct packed {
		logic [15:0]        x0;
		logic [15:0]        y0;
		logic signed [17:0] x1;
		logic signed [17:0] y1;
		logic [31:0]        pixel;
		logic               last;
	} s2_t;

	// 5x5 font, one row per entry, bit 4 is the leftmost dot
	localparam logic [4:0] GLYPH_ROM [GLYPH_COUNT][CELL_DOTS] = '{
		'{5'd0,5'd0,5'd0,5'd0,5'd0},     '{5'd4,5'd4,5'd4,5'd0,5'd4},
		'{5'd10,5'd10,5'd0,5'd0,5'd0},   '{5'd10,5'd31,5'd10,5'd31,5'd10},
		'{5'd14,5'd21,5'd28,5'd21,5'd14},'{5'd17,5'd2,5'd4,5'd8,5'd17},
		'{5'd12,5'd18,5'd20,5'd21,5'd10},'{5'd4,5'd4,5'd0,5'd0,5'd0},
		'{5'd2,5'd4,5'd8,5'd4,5'd2},     '{5'd8,5'd4,5'd2,5'd4,5'd8},
		'{5'd0,5'd21,5'd14,5'd21,5'd0},  '{5'd0,5'd4,5'd14,5'd4,5'd0},
		'{5'd0,5'd0,5'd0,5'd4,5'd8},     '{5'd0,5'd0,5'd31,5'd0,5'd0},
		'{5'd0,5'd0,5'd0,5'd0,5'd4},     '{5'd1,5'd2,5'd4,5'd8,5'd16},
		'{5'd14,5'd17,5'd19,5'd21,5'd14},'{5'd4,5'd12,5'd4,5'd4,5'd14},
		'{5'd14,5'd17,5'd2,5'd4,5'd31},  '{5'd30,5'd1,5'd6,5'd1,5'd30},
		'{5'd2,5'd6,5'd10,5'd31,5'd2},   '{5'd31,5'd16,5'd30,5'd1,5'd30},
		'{5'd14,5'd16,5'd30,5'd17,5'd14},'{5'd31,5'd1,5'd2,5'd4,5'd4},
		'{5'd14,5'd17,5'd14,5'd17,5'd14},'{5'd14,5'd17,5'd15,5'd1,5'd14},
		'{5'd0,5'd4,5'd0,5'd4,5'd0},     '{5'd0,5'd4,5'd0,5'd4,5'd8},
		'{5'd2,5'd4,5'd8,5'd4,5'd2},     '{5'd0,5'd31,5'd0,5'd31,5'd0},
		'{5'd8,5'd4,5'd2,5'd4,5'd8},     '{5'd14,5'd17,5'd2,5'd0,5'd2},
		'{5'd14,5'd17,5'd23,5'd16,5'd14},'{5'd14,5'd17,5'd17,5'd31,5'd17},
		'{5'd30,5'd17,5'd30,5'd17,5'd30},'{5'd15,5'd16,5'd16,5'd16,5'd15},
		'{5'd30,5'd17,5'd17,5'd17,5'd30},'{5'd31,5'd16,5'd30,5'd16,5'd31},
		'{5'd31,5'd16,5'd30,5'd16,5'd16},'{5'd15,5'd16,5'd23,5'd17,5'd15},
		'{5'd17,5'd17,5'd31,5'd17,5'd17},'{5'd31,5'd4,5'd4,5'd4,5'd31},
		'{5'd7,5'd2,5'd2,5'd18,5'd12},   '{5'd17,5'd18,5'd28,5'd18,5'd17},
		'{5'd16,5'd16,5'd16,5'd16,5'd31},'{5'd17,5'd27,5'd21,5'd17,5'd17},
		'{5'd17,5'd25,5'd21,5'd19,5'd17},'{5'd14,5'd17,5'd17,5'd17,5'd14},
		'{5'd30,5'd17,5'd30,5'd16,5'd16},'{5'd14,5'd17,5'd17,5'd21,5'd10},
		'{5'd30,5'd17,5'd30,5'd18,5'd17},'{5'd15,5'd16,5'd14,5'd1,5'd30},
		'{5'd31,5'd4,5'd4,5'd4,5'd4},    '{5'd17,5'd17,5'd17,5'd17,5'd14},
		'{5'd17,5'd17,5'd17,5'd10,5'd4}, '{5'd17,5'd17,5'd21,5'd27,5'd17},
		'{5'd17,5'd10,5'd4,5'd10,5'd17}, '{5'd17,5'd10,5'd4,5'd4,5'd4},
		'{5'd31,5'd2,5'd4,5'd8,5'd31},   '{5'd12,5'd8,5'd8,5'd8,5'd12},
		'{5'd16,5'd8,5'd4,5'd2,5'd1},    '{5'd6,5'd2,5'd2,5'd2,5'd6},
		'{5'd4,5'd10,5'd17,5'd0,5'd0},   '{5'd0,5'd0,5'd0,5'd0,5'd31},
		'{5'd8,5'd4,5'd0,5'd0,5'd0},     '{5'd0,5'd14,5'd1,5'd15,5'd15},
		'{5'd16,5'd30,5'd17,5'd17,5'd30},'{5'd0,5'd14,5'd16,5'd16,5'd14},
		'{5'd1,5'd15,5'd17,5'd17,5'd15}, '{5'd0,5'd14,5'd17,5'd30,5'd14},
		'{5'd6,5'd8,5'd30,5'd8,5'd8},    '{5'd0,5'd15,5'd17,5'd15,5'd1},
		'{5'd16,5'd30,5'd17,5'd17,5'd17},'{5'd4,5'd0,5'd12,5'd4,5'd14},
		'{5'd2,5'd0,5'd6,5'd2,5'd28},    '{5'd16,5'd18,5'd28,5'd18,5'd17},
		'{5'd12,5'd4,5'd4,5'd4,5'd14},   '{5'd0,5'd26,5'd21,5'd21,5'd17},
		'{5'd0,5'd30,5'd17,5'd17,5'd17}, '{5'd0,5'd14,5'd17,5'd17,5'd14},
		'{5'd0,5'd30,5'd17,5'd30,5'd16}, '{5'd0,5'd15,5'd17,5'd15,5'd1},
		'{5'd0,5'd22,5'd25,5'd16,5'd16}, '{5'd0,5'd15,5'd24,5'd7,5'd30},
		'{5'd8,5'd28,5'd8,5'd8,5'd6},    '{5'd0,5'd17,5'd17,5'd19,5'd13},
		'{5'd0,5'd17,5'd17,5'd10,5'd4},  '{5'd0,5'd17,5'd21,5'd21,5'd10},
		'{5'd0,5'd17,5'd10,5'd4,5'd10},  '{5'd0,5'd17,5'd17,5'd15,5'd1},
		'{5'd0,5'd31,5'd2,5'd8,5'd31},   '{5'd6,5'd4,5'd24,5'd4,5'd6},
		'{5'd4,5'd4,5'd4,5'd4,5'd4},     '{5'd24,5'd4,5'd3,5'd4,5'd24},
		'{5'd0,5'd10,5'd21,5'd0,5'd0}
	};

	// whole glyph as one word, top row in the high bits
	function automatic logic [GLYPH_BITS-1:0] glyph_word(input logic [7:0] code);
		logic [6:0] idx;
		idx = 7'(code - FIRST_CODE);
		if (code >= FIRST_CODE && code <= LAST_CODE) begin
			return {GLYPH_ROM[idx][0], GLYPH_ROM[idx][1], GLYPH_ROM[idx][2],
				GLYPH_ROM[idx][3], GLYPH_ROM[idx][4]};
		end
		return '0;
	endfunction

	// one 8-bit channel into its field of the pixel word
	function automatic logic [31:0] place_channel(input logic [7:0] v8,
		input logic [3:0] size, input logic [4:0] pos);
		logic [7:0] v;
		if (size == 4'd0) begin
			return '0;
		end
		v = (size < 4'd8) ? (v8 >> (4'd8 - size)) : v8;
		return {24'd0, v} << pos;
	endfunction

	// 0xRRGGBB into the configured layout
	function automatic logic [31:0] convert_rgb(input logic [23:0] rgb, input layout_t lay);
		return place_channel(rgb[23:16], lay.red_size, lay.red_pos)
			| place_channel(rgb[15:8], lay.green_size, lay.green_pos)
			| place_channel(rgb[7:0], lay.blue_size, lay.blue_pos);
	endfunction

endpackage

[rtl/core/glyph_cell_rect_generator.sv]
// Draws one 5x5 font character per request as a stream of filled rectangles:
// first the whole 5*zoom background cell, then for codes 32..126 the 25 glyph
// dots, top row first and leftmost dot first, each clipped to the screen and
// flagged visible when non-empty. A sequencer issues one rectangle per clock
// unless the output stalls, so a printable character yields 26 rectangles and
// any other code one; the next request is taken in the cycle its predecessor
// issues its final rectangle. Rectangles then pass four register stages
// (offset add, colour conversion and right/bottom edge sum, screen clamp,
// visibility and output register) on their way to the output. Configuration
// writes take effect at once and are meant to be made only while the block
// is empty.
`include "glyph_cell_rect_generator_macros.svh"

module glyph_cell_rect_generator (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [13:0] cfg_wdata,
	// draw request
	input  logic        s_tvalid,
	output logic        s_tready,
	// cell_x, cell_y, char_code, fore_rgb, back_rgb, zoom
	input  logic [95:0] s_tdata,
	// rectangle result
	output logic        m_tvalid,
	input  logic        m_tready,
	// rect_x0, rect_y0, rect_x1, rect_y1, pixel_word
	output logic [87:0] m_tdata,
	// visible
	output logic        m_tuser,
	output logic        m_tlast
);
	import gcrg_pkg::*;

	// configuration registers
	logic [13:0] screen_width_q;
	logic [13:0] screen_height_q;
	layout_t     layout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q      <= '0;
			screen_height_q     <= '0;
			layout_q.red_pos    <= 5'd16;
			layout_q.red_size   <= 4'd8;
			layout_q.green_pos  <= 5'd8;
			layout_q.green_size <= 4'd8;
			layout_q.blue_pos   <= 5'd0;
			layout_q.blue_size  <= 4'd8;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_SCREEN_WIDTH:  screen_width_q      <= cfg_wdata;
				REG_SCREEN_HEIGHT: screen_height_q     <= cfg_wdata;
				REG_RED_POS:       layout_q.red_pos    <= cfg_wdata[4:0];
				REG_RED_SIZE:      layout_q.red_size   <= cfg_wdata[3:0];
				REG_GREEN_POS:     layout_q.green_pos  <= cfg_wdata[4:0];
				REG_GREEN_SIZE:    layout_q.green_size <= cfg_wdata[3:0];
				REG_BLUE_POS:      layout_q.blue_pos   <= cfg_wdata[4:0];
				REG_BLUE_SIZE:     layout_q.blue_size  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// request fields
	logic signed [15:0] in_cell_x;
	logic signed [15:0] in_cell_y;
	logic [7:0]         in_char_code;
	logic [23:0]        in_fore_rgb;
	logic [23:0]        in_back_rgb;
	logic [7:0]         in_zoom;

	assign in_cell_x    = s_tdata[15:0];
	assign in_cell_y    = s_tdata[31:16];
	assign in_char_code = s_tdata[39:32];
	assign in_fore_rgb  = s_tdata[63:40];
	assign in_back_rgb  = s_tdata[87:64];
	assign in_zoom      = s_tdata[95:88];

	// stage valids and the backward ready chain
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4 = !vld_s4 || m_tready;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;

	// sequencer holding the current character
	logic                  busy_q;
	logic                  printable_q;
	logic [4:0]            idx_q;
	logic [2:0]            col_q;
	logic [9:0]            offx_q;
	logic [9:0]            offy_q;
	logic signed [15:0]    cx_q;
	logic signed [15:0]    cy_q;
	logic [7:0]            dot_q;
	logic [23:0]           fore_q;
	logic [23:0]           back_q;
	logic [GLYPH_BITS-1:0] glyph_q;

	logic issue;
	logic last_issue;
	logic accept;

	assign issue      = busy_q && adv_s1;
	assign last_issue = (idx_q == 5'd0) ? !printable_q : (idx_q == LAST_IDX);
	assign s_tready   = !busy_q || (issue && last_issue);
	assign accept     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (issue && last_issue) begin
			busy_q <= 1'b0;
		end
	end

	// dot walk: column and pixel offsets advance one dot per glyph-dot rectangle
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q        <= in_cell_x;
			cy_q        <= in_cell_y;
			dot_q       <= (in_zoom == 8'd0) ? 8'd1 : in_zoom;
			fore_q      <= in_fore_rgb;
			back_q      <= in_back_rgb;
			glyph_q     <= glyph_word(in_char_code);
			printable_q <= in_char_code >= FIRST_CODE && in_char_code <= LAST_CODE;
			idx_q       <= '0;
			col_q       <= '0;
			offx_q      <= '0;
			offy_q      <= '0;
		end else if (issue && !last_issue) begin
			idx_q <= idx_q + 5'd1;
			if (idx_q != 5'd0) begin
				glyph_q <= glyph_q << 1;
				if (col_q == LAST_COL) begin
					col_q  <= '0;
					offx_q <= '0;
					offy_q <= offy_q + {2'd0, dot_q};
				end else begin
					col_q  <= col_q + 3'd1;
					offx_q <= offx_q + {2'd0, dot_q};
				end
			end
		end
	end

	// stage 1: rectangle origin, size and colour choice
	s1_t s1_d, st_s1;

	always_comb begin
		s1_d.left = 17'(cx_q) + $signed({7'd0, offx_q});
		s1_d.top  = 17'(cy_q) + $signed({7'd0, offy_q});
		if (idx_q == 5'd0) begin
			s1_d.size = {1'b0, dot_q, 2'd0} + {3'd0, dot_q};
			s1_d.rgb  = back_q;
		end else begin
			s1_d.size = {3'd0, dot_q};
			s1_d.rgb  = glyph_q[GLYPH_BITS-1] ? fore_q : back_q;
		end
		s1_d.last = last_issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			st_s1 <= s1_d;
		end
	end

	// stage 2: clamp at zero, far edges, pixel conversion
	s2_t s2_d, st_s2;

	always_comb begin
		s2_d.x0    = st_s1.left[16] ? 16'd0 : st_s1.left[15:0];
		s2_d.y0    = st_s1.top[16] ? 16'd0 : st_s1.top[15:0];
		s2_d.x1    = 18'(st_s1.left) + $signed({7'd0, st_s1.size});
		s2_d.y1    = 18'(st_s1.top) + $signed({7'd0, st_s1.size});
		s2_d.pixel = convert_rgb(st_s1.rgb, layout_q);
		s2_d.last  = st_s1.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			st_s2 <= s2_d;
		end
	end

	// stage 3: clamp far edges to the screen
	s2_t s3_d, st_s3;
	logic signed [17:0] width_ext;
	logic signed [17:0] height_ext;

	assign width_ext  = $signed({4'd0, screen_width_q});
	assign height_ext = $signed({4'd0, screen_height_q});

	always_comb begin
		s3_d    = st_s2;
		s3_d.x1 = (st_s2.x1 > width_ext) ? width_ext : st_s2.x1;
		s3_d.y1 = (st_s2.y1 > height_ext) ? height_ext : st_s2.y1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && vld_s2) begin
			st_s3 <= s3_d;
		end
	end

	// stage 4: visibility and output register
	logic        vis;
	logic [13:0] x0_s4, y0_s4, x1_s4, y1_s4;
	logic [31:0] pixel_s4;
	logic        vis_s4;
	logic        last_s4;

	assign vis = ($signed({2'd0, st_s3.x0}) < st_s3.x1)
		&& ($signed({2'd0, st_s3.y0}) < st_s3.y1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && vld_s3) begin
			x0_s4    <= vis ? st_s3.x0[13:0] : 14'd0;
			y0_s4    <= vis ? st_s3.y0[13:0] : 14'd0;
			x1_s4    <= vis ? st_s3.x1[13:0] : 14'd0;
			y1_s4    <= vis ? st_s3.y1[13:0] : 14'd0;
			pixel_s4 <= st_s3.pixel;
			vis_s4   <= vis;
			last_s4  <= st_s3.last;
		end
	end

	assign m_tvalid = vld_s4;
	assign m_tdata  = {pixel_s4, y1_s4, x1_s4, y0_s4, x0_s4};
	assign m_tuser  = vis_s4;
	assign m_tlast  = last_s4;

	// checks
	`GCRG_ASSERT_SAME(a_accept_at_end, accept && busy_q, issue && last_issue,
		"request taken while a character is still being issued")
	`GCRG_ASSERT_SAME(a_dots_printable, issue && idx_q != 5'd0, printable_q,
		"glyph dot issued for an unprintable code")
	`GCRG_ASSERT_SAME(a_visible_order, m_tvalid && m_tuser, x0_s4 < x1_s4 && y0_s4 < y1_s4,
		"visible rectangle with empty extent")
	`GCRG_ASSERT_NEXT(a_hidden_zero, adv_s4 && vld_s3 && !vis,
		x0_s4 == 14'd0 && y0_s4 == 14'd0 && x1_s4 == 14'd0 && y1_s4 == 14'd0,
		"hidden rectangle with non-zero corners")

endmodule

[test/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELL = 5;

	// draw request as it travels on s_tdata, cell_x in the lowest bits
	typedef struct packed {
		logic [7:0]  zoom;
		logic [23:0] back_rgb;
		logic [23:0] fore_rgb;
		logic [7:0]  char_code;
		logic [15:0] cell_y;
		logic [15:0] cell_x;
	} draw_req_t;

	// rectangle as {m_tlast, m_tuser, m_tdata}
	typedef struct packed {
		logic        last_rect;
		logic        visible;
		logic [31:0] pixel_word;
		logic [13:0] rect_y1;
		logic [13:0] rect_x1;
		logic [13:0] rect_y0;
		logic [13:0] rect_x0;
	} rect_t;

	// 5x5 font, codes 32..126, bit 4 is the leftmost dot
	localparam logic [4:0] DOT_FONT [95][5] = '{
		'{0,0,0,0,0}, '{4,4,4,0,4}, '{10,10,0,0,0}, '{10,31,10,31,10},
		'{14,21,28,21,14}, '{17,2,4,8,17}, '{12,18,20,21,10}, '{4,4,0,0,0},
		'{2,4,8,4,2}, '{8,4,2,4,8}, '{0,21,14,21,0}, '{0,4,14,4,0},
		'{0,0,0,4,8}, '{0,0,31,0,0}, '{0,0,0,0,4}, '{1,2,4,8,16},
		'{14,17,19,21,14}, '{4,12,4,4,14}, '{14,17,2,4,31}, '{30,1,6,1,30},
		'{2,6,10,31,2}, '{31,16,30,1,30}, '{14,16,30,17,14}, '{31,1,2,4,4},
		'{14,17,14,17,14}, '{14,17,15,1,14}, '{0,4,0,4,0}, '{0,4,0,4,8},
		'{2,4,8,4,2}, '{0,31,0,31,0}, '{8,4,2,4,8}, '{14,17,2,0,2},
		'{14,17,23,16,14}, '{14,17,17,31,17}, '{30,17,30,17,30}, '{15,16,16,16,15},
		'{30,17,17,17,30}, '{31,16,30,16,31}, '{31,16,30,16,16}, '{15,16,23,17,15},
		'{17,17,31,17,17}, '{31,4,4,4,31}, '{7,2,2,18,12}, '{17,18,28,18,17},
		'{16,16,16,16,31}, '{17,27,21,17,17}, '{17,25,21,19,17}, '{14,17,17,17,14},
		'{30,17,30,16,16}, '{14,17,17,21,10}, '{30,17,30,18,17}, '{15,16,14,1,30},
		'{31,4,4,4,4}, '{17,17,17,17,14}, '{17,17,17,10,4}, '{17,17,21,27,17},
		'{17,10,4,10,17}, '{17,10,4,4,4}, '{31,2,4,8,31}, '{12,8,8,8,12},
		'{16,8,4,2,1}, '{6,2,2,2,6}, '{4,10,17,0,0}, '{0,0,0,0,31},
		'{8,4,0,0,0}, '{0,14,1,15,15}, '{16,30,17,17,30}, '{0,14,16,16,14},
		'{1,15,17,17,15}, '{0,14,17,30,14}, '{6,8,30,8,8}, '{0,15,17,15,1},
		'{16,30,17,17,17}, '{4,0,12,4,14}, '{2,0,6,2,28}, '{16,18,28,18,17},
		'{12,4,4,4,14}, '{0,26,21,21,17}, '{0,30,17,17,17}, '{0,14,17,17,14},
		'{0,30,17,30,16}, '{0,15,17,15,1}, '{0,22,25,16,16}, '{0,15,24,7,30},
		'{8,28,8,8,6}, '{0,17,17,19,13}, '{0,17,17,10,4}, '{0,17,21,21,10},
		'{0,17,10,4,10}, '{0,17,17,15,1}, '{0,31,2,8,31}, '{6,4,24,4,6},
		'{4,4,4,4,4}, '{24,4,3,4,24}, '{0,10,21,0,0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [13:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// mirror of the configuration registers
	logic [13:0] scr_w, scr_h;
	logic [4:0]  red_at, green_at, blue_at;
	logic [3:0]  red_bits, green_bits, blue_bits;

	rect_t pending_rects [$];
	int    mismatches = 0;
	bit    idle_on = 1'b1;

	glyph_cell_rect_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// one 8-bit channel into its place in the pixel word
	function automatic logic [31:0] chan_field(logic [7:0] v8, logic [3:0] nbits,
		logic [4:0] at);
		logic [31:0] v;
		if (nbits == 4'd0) begin
			return 32'd0;
		end
		v = {24'd0, v8};
		if (nbits < 4'd8) begin
			v = v >> (4'd8 - nbits);
		end
		return v << at;
	endfunction

	function automatic logic [31:0] to_pixel(logic [23:0] rgb);
		return chan_field(rgb[23:16], red_bits, red_at)
			| chan_field(rgb[15:8], green_bits, green_at)
			| chan_field(rgb[7:0], blue_bits, blue_at);
	endfunction

	// square of the given span clipped to the screen
	function automatic rect_t clip_rect(int left, int top, int span, logic [31:0] pix,
		bit last);
		rect_t r;
		int x0, y0, x1, y1;
		x0 = (left < 0) ? 0 : left;
		y0 = (top < 0) ? 0 : top;
		x1 = left + span;
		y1 = top + span;
		if (x1 > int'(scr_w)) begin
			x1 = int'(scr_w);
		end
		if (y1 > int'(scr_h)) begin
			y1 = int'(scr_h);
		end
		r = '0;
		if (x0 < x1 && y0 < y1) begin
			r.rect_x0 = x0[13:0];
			r.rect_y0 = y0[13:0];
			r.rect_x1 = x1[13:0];
			r.rect_y1 = y1[13:0];
			r.visible = 1'b1;
		end
		r.pixel_word = pix;
		r.last_rect  = last;
		return r;
	endfunction

	// background cell, then the dots of a printable glyph
	task automatic raster_cell(draw_req_t q);
		int          cx, cy, dot, r, c;
		logic [31:0] fg, bg;
		logic [4:0]  bits;
		bit          printable;
		cx = int'($signed(q.cell_x));
		cy = int'($signed(q.cell_y));
		dot = (q.zoom == 8'd0) ? 1 : int'(q.zoom);
		fg = to_pixel(q.fore_rgb);
		bg = to_pixel(q.back_rgb);
		printable = q.char_code >= gcrg_pkg::FIRST_CODE && q.char_code <= gcrg_pkg::LAST_CODE;
		pending_rects.push_back(clip_rect(cx, cy, CELL * dot, bg, !printable));
		if (printable) begin
			for (r = 0; r < CELL; r++) begin
				bits = DOT_FONT[q.char_code - gcrg_pkg::FIRST_CODE][r];
				for (c = 0; c < CELL; c++) begin
					pending_rects.push_back(clip_rect(cx + c * dot, cy + r * dot, dot,
						bits[4 - c] ? fg : bg, r == CELL - 1 && c == CELL - 1));
				end
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin : rect_check
		rect_t seen, want;
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			seen = {m_tlast, m_tuser, m_tdata};
			if (pending_rects.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected rect: x0=%0d y0=%0d x1=%0d y1=%0d pix=%h vis=%b last=%b",
						seen.rect_x0, seen.rect_y0, seen.rect_x1, seen.rect_y1,
						seen.pixel_word, seen.visible, seen.last_rect);
				end
			end else begin
				want = pending_rects.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("rect mismatch: exp x0=%0d y0=%0d x1=%0d y1=%0d pix=%h vis=%b last=%b",
							want.rect_x0, want.rect_y0, want.rect_x1, want.rect_y1,
							want.pixel_word, want.visible, want.last_rect);
						$display("               got x0=%0d y0=%0d x1=%0d y1=%0d pix=%h vis=%b last=%b",
							seen.rect_x0, seen.rect_y0, seen.rect_x1, seen.rect_y1,
							seen.pixel_word, seen.visible, seen.last_rect);
					end
				end
			end
		end
	end

	// downstream back-pressure in random bursts
	initial begin : ready_gen
		int n;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 11);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic write_reg(gcrg_pkg::reg_idx_t idx, int value);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value[13:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		case (idx)
			gcrg_pkg::REG_SCREEN_WIDTH:  scr_w = value[13:0];
			gcrg_pkg::REG_SCREEN_HEIGHT: scr_h = value[13:0];
			gcrg_pkg::REG_RED_POS:       red_at = value[4:0];
			gcrg_pkg::REG_RED_SIZE:      red_bits = value[3:0];
			gcrg_pkg::REG_GREEN_POS:     green_at = value[4:0];
			gcrg_pkg::REG_GREEN_SIZE:    green_bits = value[3:0];
			gcrg_pkg::REG_BLUE_POS:      blue_at = value[4:0];
			gcrg_pkg::REG_BLUE_SIZE:     blue_bits = value[3:0];
			default: ;
		endcase
	endtask

	task automatic set_screen(int w, int h);
		write_reg(gcrg_pkg::REG_SCREEN_WIDTH, w);
		write_reg(gcrg_pkg::REG_SCREEN_HEIGHT, h);
	endtask

	task automatic set_layout(int rp, int rs, int gp, int gs, int bp, int bs);
		write_reg(gcrg_pkg::REG_RED_POS, rp);
		write_reg(gcrg_pkg::REG_RED_SIZE, rs);
		write_reg(gcrg_pkg::REG_GREEN_POS, gp);
		write_reg(gcrg_pkg::REG_GREEN_SIZE, gs);
		write_reg(gcrg_pkg::REG_BLUE_POS, bp);
		write_reg(gcrg_pkg::REG_BLUE_SIZE, bs);
	endtask

	// present one request and hold it until taken
	task automatic send_req(draw_req_t q);
		s_tdata  <= q;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		raster_cell(q);
	endtask

	task automatic maybe_pause();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_rects.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic draw_req_t make_req(int x, int y, int code, int fg, int bg, int zoom);
		draw_req_t q;
		q.cell_x    = x[15:0];
		q.cell_y    = y[15:0];
		q.char_code = code[7:0];
		q.fore_rgb  = fg[23:0];
		q.back_rgb  = bg[23:0];
		q.zoom      = zoom[7:0];
		return q;
	endfunction

	// mostly printable cells around the visible area, some full-range noise
	function automatic draw_req_t random_req();
		int z, span, x, y, code;
		case ($urandom_range(0, 9))
			0: z = $urandom_range(0, 255);
			1, 2: z = $urandom_range(7, 40);
			default: z = $urandom_range(0, 6);
		endcase
		span = CELL * ((z == 0) ? 1 : z);
		code = ($urandom_range(0, 9) < 8) ? $urandom_range(32, 126) : $urandom_range(0, 255);
		if ($urandom_range(0, 7) == 0) begin
			x = $urandom_range(0, 65535);
			y = $urandom_range(0, 65535);
		end else begin
			x = $urandom_range(0, int'(scr_w) + span) - span;
			y = $urandom_range(0, int'(scr_h) + span) - span;
		end
		return make_req(x, y, code, $urandom_range(0, 24'hFFFFFF),
			$urandom_range(0, 24'hFFFFFF), z);
	endfunction

	function automatic int random_size();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(4, 8);
	endfunction

	task automatic random_setup();
		if ($urandom_range(0, 9) == 0) begin
			set_screen($urandom_range(0, 16383), $urandom_range(0, 16383));
		end else begin
			set_screen($urandom_range(1, 120), $urandom_range(1, 120));
		end
		set_layout($urandom_range(0, 31), random_size(), $urandom_range(0, 31),
			random_size(), $urandom_range(0, 31), random_size());
	endtask

	// reset values: zero-sized screen, so nothing is visible
	task automatic test_reset_defaults();
		send_req(make_req(0, 0, 8'h41, 24'hFFFFFF, 24'h123456, 1));
		send_req(make_req(3, 4, 8'h07, 24'hABCDEF, 24'hFEDCBA, 2));
		wait_drained();
	endtask

	// clipping on every edge, code boundaries, zoom extremes
	task automatic test_clipping_and_codes();
		set_screen(100, 60);
		send_req(make_req(10, 10, 8'h41, 24'hFFFFFF, 24'h000000, 1));
		send_req(make_req(-3, -2, 8'h23, 24'h00FF00, 24'hFF0000, 2));
		send_req(make_req(95, 57, 8'h57, 24'h0000FF, 24'h808080, 3));
		send_req(make_req(0, 0, 8'h00, 24'hFFFFFF, 24'h000000, 0));
		send_req(make_req(5, 5, 8'h1F, 24'h112233, 24'h445566, 1));
		send_req(make_req(5, 5, 8'h20, 24'h112233, 24'h445566, 1));
		send_req(make_req(5, 5, 8'h7E, 24'h112233, 24'h445566, 1));
		send_req(make_req(5, 5, 8'h7F, 24'h112233, 24'h445566, 1));
		send_req(make_req(5, 5, 8'hFF, 24'h112233, 24'h445566, 1));
		send_req(make_req(-32768, -32768, 8'h42, 24'hFFFFFF, 24'h000000, 255));
		send_req(make_req(32767, 32767, 8'h43, 24'h000000, 24'hFFFFFF, 255));
		wait_drained();
		set_screen(16383, 16383);
		send_req(make_req(16300, 16300, 8'h4D, 24'hFFFFFF, 24'h000000, 255));
		send_req(make_req(0, 0, 8'h40, 24'hC0FFEE, 24'h0BADF0, 255));
		send_req(make_req(-32768, 32767, 8'h78, 24'hFFFFFF, 24'hFFFFFF, 255));
		wait_drained();
		set_screen(1, 1);
		send_req(make_req(0, 0, 8'h2E, 24'hFFFFFF, 24'h000000, 0));
		wait_drained();
	endtask

	// colour conversion: omitted, narrow, wide, oversized and shifted-out channels
	task automatic test_pixel_layouts();
		set_screen(64, 64);
		set_layout(11, 5, 5, 6, 0, 5);
		send_req(make_req(2, 2, 8'h41, 24'hA5C3F0, 24'h5A3C0F, 1));
		wait_drained();
		set_layout(16, 0, 8, 0, 0, 0);
		send_req(make_req(2, 2, 8'h42, 24'hFFFFFF, 24'h7F7F7F, 1));
		wait_drained();
		set_layout(31, 1, 30, 1, 29, 1);
		send_req(make_req(2, 2, 8'h43, 24'h808080, 24'h7F7F7F, 1));
		wait_drained();
		set_layout(24, 15, 12, 9, 0, 12);
		send_req(make_req(2, 2, 8'h44, 24'hA5C3F0, 24'h5A3C0F, 1));
		wait_drained();
		set_layout(28, 8, 31, 8, 20, 8);
		send_req(make_req(2, 2, 8'h45, 24'hFFFFFF, 24'hA5C3F0, 1));
		wait_drained();
		set_layout(20, 7, 10, 3, 2, 2);
		send_req(make_req(2, 2, 8'h46, 24'hFEDCBA, 24'h013579, 1));
		wait_drained();
	endtask

	// random cells under several random settings, draining between them
	task automatic test_random_draws();
		int phase, k;
		for (phase = 0; phase < 4; phase++) begin
			random_setup();
			for (k = 0; k < 24; k++) begin
				maybe_pause();
				send_req(random_req());
			end
			wait_drained();
		end
	endtask

	// back-to-back requests with full downstream throughput
	task automatic test_no_idling();
		int k;
		idle_on = 1'b0;
		set_screen(80, 48);
		set_layout(16, 8, 8, 8, 0, 8);
		for (k = 0; k < 30; k++) begin
			send_req(random_req());
		end
		wait_drained();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = gcrg_pkg::REG_SCREEN_WIDTH;
		cfg_wdata = 14'd0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		scr_w      = 14'd0;
		scr_h      = 14'd0;
		red_at     = 5'd16;
		red_bits   = 4'd8;
		green_at   = 5'd8;
		green_bits = 4'd8;
		blue_at    = 5'd0;
		blue_bits  = 4'd8;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_clipping_and_codes();
		test_pixel_layouts();
		test_random_draws();
		test_no_idling();
		if (mismatches == 0 && pending_rects.size() == 0) begin
			$display("glyph_cell_rect_generator test passed");
		end else begin
			$display("glyph_cell_rect_generator test failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#6ms;
		$display("glyph_cell_rect_generator test failed");
		$finish;
	end

endmodule
